@@ rtl/core/esc_pkg.sv @@
// Shared constants, types and helper functions of the sensor compensation block.
package esc_pkg;

  localparam int NUM_COEF  = 8;
  localparam int IDX_W     = $clog2(NUM_COEF);
  localparam int CFG_AW    = IDX_W + 2;

  // Stage counts of the datapath parts.
  localparam int TF_LAT    = 3;
  localparam int T_LAT     = 4;
  localparam int H_LAT     = 7;
  localparam int DIV_STEPS = 64;
  localparam int P_LAT     = 6 + DIV_STEPS + 5;
  localparam int TOT_LAT   = TF_LAT + P_LAT;
  localparam int TEMP_DLY  = TOT_LAT - T_LAT;
  localparam int HUM_DLY   = TOT_LAT - TF_LAT - H_LAT;

  localparam logic [31:0] HUM_CLAMP = 32'd419430400;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [7:0]  h3;
    logic [15:0] h2;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } coef_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } div_side_t;

  function automatic coef_t unpack_coef(input logic [NUM_COEF-1:0][31:0] w);
    coef_t c;
    c.t1 = w[0][15:0];
    c.t2 = w[0][31:16];
    c.t3 = w[1][15:0];
    c.p1 = w[1][31:16];
    c.p2 = w[2][15:0];
    c.p3 = w[2][31:16];
    c.p4 = w[3][15:0];
    c.p5 = w[3][31:16];
    c.p6 = w[4][15:0];
    c.p7 = w[4][31:16];
    c.p8 = w[5][15:0];
    c.p9 = w[5][31:16];
    c.h1 = w[6][7:0];
    c.h3 = w[6][15:8];
    c.h2 = w[6][31:16];
    c.h4 = w[7][11:0];
    c.h5 = w[7][23:12];
    c.h6 = w[7][31:24];
    return c;
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16to32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx16to64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

@@ rtl/core/esc_if.sv @@
// Handshake channels for raw samples and compensated results.
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface esc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temp_milli_c;
  logic        [31:0] pressure_pa;
  logic        [16:0] humidity_milli_rh;

  modport source (output valid, temp_milli_c, pressure_pa, humidity_milli_rh, input ready);
  modport sink   (input valid, temp_milli_c, pressure_pa, humidity_milli_rh, output ready);
endinterface

@@ rtl/core/esc_temp.sv @@
// Temperature path: fine temperature term and milli-degree result.
module esc_temp (
  input  logic           clk,
  input  logic           adv,
  input  logic [19:0]    raw_t,
  input  esc_pkg::coef_t coef,
  output logic [31:0]    t_fine,
  output logic [31:0]    temp
);
  import esc_pkg::*;

  logic [31:0] d_w, e_w;
  logic [31:0] m1_r, m1_nxt, dd_r, dd_nxt;
  logic [31:0] v1_r, v1_nxt, m2_r, m2_nxt;
  logic [31:0] tf_r, tf_nxt, temp_r, temp_nxt;

  always_comb begin
    d_w      = {16'd0, raw_t[19:4]} - {16'd0, coef.t1};
    e_w      = {15'd0, raw_t[19:3]} - {15'd0, coef.t1, 1'b0};
    m1_nxt   = e_w * sx16to32(coef.t2);
    dd_nxt   = d_w * d_w;
    v1_nxt   = asr32(m1_r, 11);
    m2_nxt   = asr32(dd_r, 12) * sx16to32(coef.t3);
    tf_nxt   = v1_r + asr32(m2_r, 14);
    temp_nxt = asr32(tf_r * 32'd5 + 32'd128, 8) * 32'd10;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r   <= m1_nxt;
      dd_r   <= dd_nxt;
      v1_r   <= v1_nxt;
      m2_r   <= m2_nxt;
      tf_r   <= tf_nxt;
      temp_r <= temp_nxt;
    end
  end

  assign t_fine = tf_r;
  assign temp   = temp_r;
endmodule

@@ rtl/core/esc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
module esc_div (
  input  logic               clk,
  input  logic               adv,
  input  logic [63:0]        num,
  input  logic [30:0]        den,
  input  esc_pkg::div_side_t side_i,
  output logic [63:0]        quo,
  output esc_pkg::div_side_t side_o
);
  import esc_pkg::*;

  logic [30:0]     rem_r  [DIV_STEPS];
  logic [63:0]     nq_r   [DIV_STEPS];
  logic [30:0]     dn_r   [DIV_STEPS];
  div_side_t       sd_r   [DIV_STEPS];

  genvar k;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [30:0] rem_in;
      logic [63:0] nq_in;
      logic [30:0] dn_in;
      div_side_t   sd_in;
      logic [31:0] trial;
      logic        ge;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign nq_in  = num;
        assign dn_in  = den;
        assign sd_in  = side_i;
      end else begin : g_rest
        assign rem_in = rem_r[k-1];
        assign nq_in  = nq_r[k-1];
        assign dn_in  = dn_r[k-1];
        assign sd_in  = sd_r[k-1];
      end

      assign trial = {rem_in, nq_in[63]};
      assign ge    = (trial >= {1'b0, dn_in});

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k] <= ge ? 31'(trial - {1'b0, dn_in}) : trial[30:0];
          nq_r[k]  <= {nq_in[62:0], ge};
          dn_r[k]  <= dn_in;
          sd_r[k]  <= sd_in;
        end
      end
    end
  endgenerate

  assign quo    = nq_r[DIV_STEPS-1];
  assign side_o = sd_r[DIV_STEPS-1];
endmodule

@@ rtl/core/esc_press.sv @@
// Pressure path: 64-bit polynomial terms, pipelined division and final correction.
module esc_press (
  input  logic           clk,
  input  logic           adv,
  input  logic [31:0]    t_fine,
  input  logic [19:0]    raw_p,
  input  esc_pkg::coef_t coef,
  output logic [31:0]    press
);
  import esc_pkg::*;

  // Stage 1
  logic signed [32:0] a33;
  logic signed [65:0] aa_full;
  logic signed [63:0] ap5_w, ap2_w;
  logic [63:0] aa_r, ap5_r, ap2_r;
  logic [19:0] adcp1_r, adcp2_r;
  // Stage 2
  logic [63:0] b_r, b_nxt, aa3_r, aa3_nxt, ap2b_r;
  // Stage 3
  logic [20:0] pp_w;
  logic [63:0] s_r, s_nxt, n0_r, n0_nxt;
  // Stage 4
  logic [63:0] prod_r, num_r;
  // Stage 5
  logic [63:0] den_w;
  logic [30:0] den_r;
  logic [63:0] num5_r;
  // Stage 6
  logic [63:0] magn_r;
  logic [30:0] magd_r;
  div_side_t   side6_r;
  // Divider output and sign fix
  logic [63:0] quo_w;
  div_side_t   sidq_w;
  logic [63:0] q_r;
  logic        z_q_r;
  // Correction stages
  logic [63:0] sh_w;
  logic [63:0] m1_r, sh_r, q2p_r, q1c_r;
  logic        z1_r;
  logic [63:0] ll_r, q2c_r, qcc_r;
  logic [31:0] cr_r;
  logic        z2_r;
  logic [63:0] sum_r, sum_nxt;
  logic        z3_r;
  logic [63:0] pv_w;
  logic [31:0] press_r;

  always_comb begin
    a33     = $signed({t_fine[31], t_fine}) - 33'sd128000;
    aa_full = a33 * a33;
    ap5_w   = a33 * $signed(coef.p5);
    ap2_w   = a33 * $signed(coef.p2);
    b_nxt   = aa_r * sx16to64(coef.p6) + (ap5_r << 17) + (sx16to64(coef.p4) << 35);
    aa3_nxt = aa_r * sx16to64(coef.p3);
    pp_w    = 21'd1048576 - {1'b0, adcp2_r};
    s_nxt   = 64'h0000_8000_0000_0000 + asr64(aa3_r, 8) + (ap2b_r << 12);
    n0_nxt  = ({43'd0, pp_w} << 31) - b_r;
    den_w   = asr64(prod_r, 33);
    sh_w    = asr64(q_r, 13);
    sum_nxt = q2c_r + asr64(ll_r + {cr_r, 32'd0}, 25) + qcc_r;
    pv_w    = asr64(sum_r, 8) + (sx16to64(coef.p7) << 4);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      aa_r    <= aa_full[63:0];
      ap5_r   <= $unsigned(ap5_w);
      ap2_r   <= $unsigned(ap2_w);
      adcp1_r <= raw_p;

      b_r     <= b_nxt;
      aa3_r   <= aa3_nxt;
      ap2b_r  <= ap2_r;
      adcp2_r <= adcp1_r;

      s_r     <= s_nxt;
      n0_r    <= n0_nxt;

      prod_r  <= s_r * {48'd0, coef.p1};
      num_r   <= n0_r * 64'd3125;

      den_r   <= den_w[30:0];
      num5_r  <= num_r;

      magn_r       <= num5_r[63] ? (64'd0 - num5_r) : num5_r;
      magd_r       <= den_r[30] ? (31'd0 - den_r) : den_r;
      side6_r.neg  <= num5_r[63] ^ den_r[30];
      side6_r.zero <= (den_r == '0);

      q_r   <= sidq_w.neg ? (64'd0 - quo_w) : quo_w;
      z_q_r <= sidq_w.zero;

      m1_r  <= sh_w * sx16to64(coef.p9);
      sh_r  <= sh_w;
      q2p_r <= q_r * sx16to64(coef.p8);
      q1c_r <= q_r;
      z1_r  <= z_q_r;

      ll_r  <= {32'd0, m1_r[31:0]} * {32'd0, sh_r[31:0]};
      cr_r  <= 32'(m1_r[63:32] * sh_r[31:0]) + 32'(m1_r[31:0] * sh_r[63:32]);
      q2c_r <= q1c_r;
      qcc_r <= asr64(q2p_r, 19);
      z2_r  <= z1_r;

      sum_r <= sum_nxt;
      z3_r  <= z2_r;

      press_r <= z3_r ? 32'd0 : pv_w[39:8];
    end
  end

  esc_div u_div (
    .clk    (clk),
    .adv    (adv),
    .num    (magn_r),
    .den    (magd_r),
    .side_i (side6_r),
    .quo    (quo_w),
    .side_o (sidq_w)
  );

  assign press = press_r;
endmodule

@@ rtl/core/esc_hum.sv @@
// Humidity path: 32-bit wrapped compensation, clamp and milli-percent scaling.
module esc_hum (
  input  logic           clk,
  input  logic           adv,
  input  logic [31:0]    t_fine,
  input  logic [15:0]    raw_h,
  input  esc_pkg::coef_t coef,
  output logic [16:0]    hum
);
  import esc_pkg::*;

  logic [31:0] h_w;
  logic [31:0] xi_r, xi_nxt, hh6_r, hh3_r;
  logic [31:0] x2_r, ya_r, ya_nxt;
  logic [31:0] x3_r, ym_r, ym_nxt;
  logic [31:0] y_w, hv4_r;
  logic [31:0] s_w, hv5_r, sq_r;
  logic [31:0] hv6_r, t_r;
  logic [31:0] hc_w, hcl_w;
  logic [26:0] sc_w;
  logic [16:0] hum_r;

  always_comb begin
    h_w    = t_fine - 32'd76800;
    xi_nxt = {2'd0, raw_h, 14'd0} - {coef.h4, 20'd0}
             - h_w * {{20{coef.h5[11]}}, coef.h5} + 32'd16384;
    ya_nxt = asr32(hh6_r, 10) * (asr32(hh3_r, 11) + 32'd32768);
    ym_nxt = (asr32(ya_r, 10) + 32'd2097152) * sx16to32(coef.h2);
    y_w    = asr32(ym_r + 32'd8192, 14);
    s_w    = asr32(hv4_r, 15);
    hc_w   = hv6_r - asr32(t_r, 4);
    if (hc_w[31]) begin
      hcl_w = '0;
    end else if (hc_w > HUM_CLAMP) begin
      hcl_w = HUM_CLAMP;
    end else begin
      hcl_w = hc_w;
    end
    sc_w = {7'd0, hcl_w[31:12]} * 27'd1000;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xi_r  <= xi_nxt;
      hh6_r <= h_w * {{24{coef.h6[7]}}, coef.h6};
      hh3_r <= h_w * {24'd0, coef.h3};
      x2_r  <= asr32(xi_r, 15);
      ya_r  <= ya_nxt;
      x3_r  <= x2_r;
      ym_r  <= ym_nxt;
      hv4_r <= x3_r * y_w;
      hv5_r <= hv4_r;
      sq_r  <= s_w * s_w;
      hv6_r <= hv5_r;
      t_r   <= asr32(sq_r, 7) * {24'd0, coef.h1};
      hum_r <= sc_w[26:10];
    end
  end

  assign hum = hum_r;
endmodule

@@ rtl/core/env_sensor_compensation_top.sv @@
// Top level of the environmental sensor compensation block.
// Takes one raw triple (temperature, pressure, humidity ADC codes) per item and returns
// temperature in milli-degrees C, pressure in Pa and humidity in milli-percent RH. The
// datapath is a single pipeline that accepts an item every cycle while it is not held; each
// item passes the fine temperature stages and then the pressure path, mostly the 64-stage
// pressure divider (one quotient bit per stage). The whole pipeline advances together and
// holds when the output register carries an item the sink has not taken, so in_ready
// follows out_ready whenever the output is occupied. The eight calibration words are
// written over the APB port at byte address 4*i, reset to zero, and must be written only
// while no item is in flight. There is no clearing pass after reset.
module env_sensor_compensation_top (
  input  logic                         clk,
  input  logic                         rst_n,
  esc_in_if.sink                       in_ch,
  esc_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [esc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import esc_pkg::*;

  logic [NUM_COEF-1:0][31:0] coef_r;
  coef_t                     coef;
  logic [IDX_W-1:0]          cfg_idx;

  logic                      adv;
  logic [TOT_LAT-1:0]        vld_r;

  logic [19:0]               rp_r   [TF_LAT];
  logic [15:0]               rh_r   [TF_LAT];
  logic [31:0]               temp_d_r [TEMP_DLY];
  logic [16:0]               hum_d_r  [HUM_DLY];

  logic [31:0]               t_fine, temp, press;
  logic [16:0]               hum;

  // Configuration: write on the access phase, ignore the low address bits.
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = coef_r[cfg_idx];
  assign coef       = unpack_coef(coef_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      coef_r[cfg_idx] <= cfg_pwdata;
    end
  end

  // Advance the whole pipeline unless the output holds an untaken item.
  assign adv         = !vld_r[TOT_LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TOT_LAT-2:0], in_ch.valid};
    end
  end

  // Align raw pressure and humidity codes with the fine temperature term.
  always_ff @(posedge clk) begin
    if (adv) begin
      rp_r[0] <= in_ch.raw_pressure;
      rh_r[0] <= in_ch.raw_humidity;
      for (int i = 1; i < TF_LAT; i++) begin
        rp_r[i] <= rp_r[i-1];
        rh_r[i] <= rh_r[i-1];
      end
    end
  end

  esc_temp u_temp (
    .clk    (clk),
    .adv    (adv),
    .raw_t  (in_ch.raw_temperature),
    .coef   (coef),
    .t_fine (t_fine),
    .temp   (temp)
  );

  esc_press u_press (
    .clk    (clk),
    .adv    (adv),
    .t_fine (t_fine),
    .raw_p  (rp_r[TF_LAT-1]),
    .coef   (coef),
    .press  (press)
  );

  esc_hum u_hum (
    .clk    (clk),
    .adv    (adv),
    .t_fine (t_fine),
    .raw_h  (rh_r[TF_LAT-1]),
    .coef   (coef),
    .hum    (hum)
  );

  // Delay temperature and humidity results to meet the pressure result.
  always_ff @(posedge clk) begin
    if (adv) begin
      temp_d_r[0] <= temp;
      hum_d_r[0]  <= hum;
      for (int i = 1; i < TEMP_DLY; i++) begin
        temp_d_r[i] <= temp_d_r[i-1];
      end
      for (int i = 1; i < HUM_DLY; i++) begin
        hum_d_r[i] <= hum_d_r[i-1];
      end
    end
  end

  assign out_ch.valid             = vld_r[TOT_LAT-1];
  assign out_ch.temp_milli_c      = $signed(temp_d_r[TEMP_DLY-1]);
  assign out_ch.pressure_pa       = press;
  assign out_ch.humidity_milli_rh = hum_d_r[HUM_DLY-1];
endmodule

@@ test/env_sensor_compensation_checker.sv @@
// Watches the sample, result and calibration ports, predicts each result and compares it.
`timescale 1ns / 100ps

module env_sensor_compensation_checker (
  input  logic        clk,
  input  logic        rst_n,
  esc_in_if           in_ch,
  esc_out_if          out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [esc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          error_count,
  output int          pending_count,
  output int          reading_count
);
  import esc_pkg::*;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
  } reading_t;

  logic [31:0] coef_words [NUM_COEF];
  reading_t    expected_readings [$];

  function automatic logic [31:0] shr32(input logic [31:0] v, input int s);
    logic signed [31:0] sv;
    sv = v;
    return sv >>> s;
  endfunction

  function automatic logic [63:0] shr64(input logic [63:0] v, input int s);
    logic signed [63:0] sv;
    sv = v;
    return sv >>> s;
  endfunction

  function automatic logic [31:0] ext32(input logic [31:0] v, input int w);
    logic [31:0] m;
    m = 32'd1 << (w - 1);
    v = v & ((m << 1) - 32'd1);
    return (v ^ m) - m;
  endfunction

  function automatic logic [63:0] ext64(input logic [31:0] v, input int w);
    logic [31:0] e;
    e = ext32(v, w);
    return {{32{e[31]}}, e};
  endfunction

  function automatic logic [63:0] quot64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? 64'd0 - a : a;
    mb = b[63] ? 64'd0 - b : b;
    q  = ma / mb;
    return (a[63] != b[63]) ? 64'd0 - q : q;
  endfunction

  // Compensate one raw triple with the current calibration words.
  function automatic reading_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p,
                                          input logic [15:0] raw_h);
    logic [31:0] adc_t, adc_h, t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0] d, v1, v2, t_fine, t_centi, h, x, y;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, q1, q2;
    reading_t r;
    adc_t = {12'd0, raw_t};
    adc_h = {16'd0, raw_h};
    t1 = {16'd0, coef_words[0][15:0]};
    t2 = ext32(coef_words[0] >> 16, 16);
    t3 = ext32(coef_words[1], 16);
    p1 = {48'd0, coef_words[1][31:16]};
    p2 = ext64(coef_words[2], 16);
    p3 = ext64(coef_words[2] >> 16, 16);
    p4 = ext64(coef_words[3], 16);
    p5 = ext64(coef_words[3] >> 16, 16);
    p6 = ext64(coef_words[4], 16);
    p7 = ext64(coef_words[4] >> 16, 16);
    p8 = ext64(coef_words[5], 16);
    p9 = ext64(coef_words[5] >> 16, 16);
    h1 = {24'd0, coef_words[6][7:0]};
    h3 = {24'd0, coef_words[6][15:8]};
    h2 = ext32(coef_words[6] >> 16, 16);
    h4 = ext32(coef_words[7], 12);
    h5 = ext32(coef_words[7] >> 12, 12);
    h6 = ext32(coef_words[7] >> 24, 8);

    // temperature, wraps at 32 bits
    d       = (adc_t >> 4) - t1;
    v1      = shr32(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    v2      = shr32(shr32(d * d, 12) * t3, 14);
    t_fine  = v1 + v2;
    t_centi = shr32(t_fine * 32'd5 + 32'd128, 8);
    r.temp  = t_centi * 32'd10;

    // pressure, wraps at 64 bits; a zero divisor yields zero
    a = {{32{t_fine[31]}}, t_fine} - 64'd128000;
    b = a * a * p6;
    b = b + a * p5 * 64'd131072;
    b = b + p4 * (64'd1 << 35);
    a = shr64(a * a * p3, 8) + a * p2 * 64'd4096;
    a = shr64(((64'd1 << 47) + a) * p1, 33);
    r.press = '0;
    if (a != 64'd0) begin
      p  = 64'd1048576 - {44'd0, raw_p};
      p  = quot64((p * (64'd1 << 31) - b) * 64'd3125, a);
      q1 = shr64(p9 * shr64(p, 13) * shr64(p, 13), 25);
      q2 = shr64(p8 * p, 19);
      p  = shr64(p + q1 + q2, 8) + p7 * 64'd16;
      r.press = p[39:8];
    end

    // humidity, wraps at 32 bits, clamped before scaling
    h = t_fine - 32'd76800;
    x = shr32((adc_h << 14) - h4 * 32'd1048576 - h5 * h + 32'd16384, 15);
    y = shr32(shr32(h * h6, 10) * (shr32(h * h3, 11) + 32'd32768), 10);
    y = shr32((y + 32'd2097152) * h2 + 32'd8192, 14);
    h = x * y;
    h = h - shr32(shr32(shr32(h, 15) * shr32(h, 15), 7) * h1, 4);
    if (h[31]) h = '0;
    else if (h > HUM_CLAMP) h = HUM_CLAMP;
    h = ((h >> 12) * 32'd1000) / 32'd1024;
    r.hum = h[16:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  initial begin
    error_count   = 0;
    reading_count = 0;
    for (int i = 0; i < NUM_COEF; i++) coef_words[i] = '0;
  end

  assign pending_count = expected_readings.size();

  // Sample at the falling edge: what is seen here is what the next rising edge takes.
  always @(negedge clk) begin
    reading_t got, want;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        coef_words[cfg_paddr[CFG_AW-1:2]] = cfg_pwdata;
      if (in_ch.valid && in_ch.ready)
        expected_readings.push_back(compensate(in_ch.raw_temperature, in_ch.raw_pressure,
                                               in_ch.raw_humidity));
      if (out_ch.valid && out_ch.ready) begin
        got.temp  = out_ch.temp_milli_c;
        got.press = out_ch.pressure_pa;
        got.hum   = out_ch.humidity_milli_rh;
        reading_count++;
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result", got.temp, '0);
        end else begin
          want = expected_readings.pop_front();
          if (got.temp !== want.temp) report_mismatch("temp_milli_c", got.temp, want.temp);
          if (got.press !== want.press) report_mismatch("pressure_pa", got.press, want.press);
          if (got.hum !== want.hum)
            report_mismatch("humidity_milli_rh", {15'd0, got.hum}, {15'd0, want.hum});
        end
      end
    end
  end
endmodule

@@ test/tb_env_sensor_compensation_top.sv @@
// Top of the compensation testbench: clock, reset, stimulus, calibration phases and verdict.
`timescale 1ns / 100ps

module tb_env_sensor_compensation_top;
  import esc_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  int                error_count, pending_count, reading_count;
  int                sent_count;
  bit                no_idle;       // stretch with no gaps on either side
  bit                stim_done;

  esc_in_if  in_if();
  esc_out_if out_if();

  env_sensor_compensation_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  env_sensor_compensation_checker checker_inst (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .error_count   (error_count),
    .pending_count (pending_count),
    .reading_count (reading_count)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Drive every input to a known value from time zero.
  initial begin
    rst_n                 <= 1'b0;
    cfg_psel              <= 1'b0;
    cfg_penable           <= 1'b0;
    cfg_pwrite            <= 1'b0;
    cfg_paddr             <= '0;
    cfg_pwdata            <= '0;
    in_if.valid           <= 1'b0;
    in_if.raw_temperature <= '0;
    in_if.raw_pressure    <= '0;
    in_if.raw_humidity    <= '0;
    out_if.ready          <= 1'b0;
  end

  // Write one calibration word: setup cycle, then access cycle.
  task automatic write_coef(input int idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(idx * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic load_coefs(input logic [31:0] w [NUM_COEF]);
    for (int i = 0; i < NUM_COEF; i++) write_coef(i, w[i]);
  endtask

  // Offer one sample; hold it until the block takes it.
  task automatic send_sample(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
    int  gap;
    bit  rdy;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.raw_temperature <= t;
    in_if.raw_pressure    <= p;
    in_if.raw_humidity    <= h;
    forever begin
      @(negedge clk);
      rdy = in_if.ready;
      @(posedge clk);
      if (rdy) break;
    end
    sent_count++;
  endtask

  // Drop valid and wait until every accepted item has come back.
  task automatic drain;
    in_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    @(posedge clk);
  endtask

  // Raw codes: mostly around the working range, the rest anywhere.
  task automatic send_random(input int n);
    logic [19:0] t, p;
    logic [15:0] h;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        t = 20'($urandom);
        p = 20'($urandom);
        h = 16'($urandom);
      end else begin
        t = 20'd400000 + 20'($urandom_range(0, 300000));
        p = 20'd250000 + 20'($urandom_range(0, 300000));
        h = 16'd15000 + 16'($urandom_range(0, 40000));
      end
      send_sample(t, p, h);
    end
    no_idle = 1'b0;
  endtask

  // Consumer: stall a random number of cycles before taking each result.
  initial begin
    int stall;
    bit vld;
    @(posedge clk);
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      forever begin
        @(negedge clk);
        vld = out_if.valid;
        @(posedge clk);
        if (vld) break;
      end
    end
  end

  initial begin
    logic [31:0] typical [NUM_COEF];
    logic [31:0] words   [NUM_COEF];
    sent_count = 0;
    no_idle    = 1'b0;
    stim_done  = 1'b0;

    // Typical factory calibration.
    typical[0] = {16'd26435, 16'd27504};
    typical[1] = {16'd36477, 16'hFC18};
    typical[2] = {16'd3024,  16'hD643};
    typical[3] = {16'd140,   16'd2855};
    typical[4] = {16'd15500, 16'hFFF9};
    typical[5] = {16'd6000,  16'hC6F8};
    typical[6] = {16'd362,   8'd0, 8'd75};
    typical[7] = {8'd30, 12'd50, 12'd313};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients: the pressure divisor is zero, so pressure must read 0.
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_random(40);
    drain();

    // Directed: field extremes and a nominal point under typical calibration.
    load_coefs(typical);
    for (int k = 0; k < 8; k++)
      send_sample(k[0] ? '1 : '0, k[1] ? '1 : '0, k[2] ? '1 : '0);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    send_sample(20'd519888, 20'd1048575, 16'd65535);
    send_sample(20'd1048575, 20'd415148, 16'd0);
    send_sample(20'd300000, 20'd0, 16'd12000);    // very cold, humidity clamps low
    send_sample(20'd700000, 20'd500000, 16'd60000); // hot and wet, humidity clamps high
    send_random(700);
    drain();

    // All ones: every signed coefficient at -1, unsigned ones at maximum.
    for (int i = 0; i < NUM_COEF; i++) words[i] = '1;
    load_coefs(words);
    send_random(200);
    drain();

    // Signed coefficients at their most positive value.
    for (int i = 0; i < NUM_COEF; i++) words[i] = 32'h7FFF_7FFF;
    words[6] = 32'h7FFF_FFFF;
    words[7] = 32'h7F7F_F7FF;
    load_coefs(words);
    send_random(200);
    drain();

    // Signed coefficients at their most negative value.
    for (int i = 0; i < NUM_COEF; i++) words[i] = 32'h8000_8000;
    words[6] = 32'h8000_0000;
    words[7] = 32'h8080_0800;
    load_coefs(words);
    send_random(200);
    drain();

    // Fully random calibration words, several sets.
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < NUM_COEF; i++) words[i] = $urandom;
      load_coefs(words);
      send_random(100);
      drain();
    end

    // Back to typical calibration with a final random run.
    load_coefs(typical);
    send_random(150);
    in_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Wrap up once all results are in and the pipeline has had time to flush.
  initial begin
    wait (stim_done);
    wait (pending_count == 0);
    repeat (TOT_LAT + 20) @(posedge clk);
    $display("Covered %0d samples and %0d results over reset, typical, extreme and random",
             sent_count, reading_count);
    $display("calibration sets, with random gaps and stalls on both channels.");
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #5000000;
    $display("Timeout: %0d results still outstanding", pending_count);
    $display("DONE: errors detected");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/esc_pkg.sv
rtl/core/esc_if.sv
rtl/core/esc_temp.sv
rtl/core/esc_div.sv
rtl/core/esc_press.sv
rtl/core/esc_hum.sv
rtl/core/env_sensor_compensation_top.sv
test/env_sensor_compensation_checker.sv
test/tb_env_sensor_compensation_top.sv
